/* hw/rtl/tra_pkg.sv */
package tra_pkg;

  localparam int CAPACITY = 1024;
  localparam int SL_LOG2  = 2;
  localparam int LIN_LOG2 = 6;
  localparam int NUM_SL   = 1 << SL_LOG2;
  localparam int NUM_FL   = 8;
  localparam int FL_W     = 3;
  localparam int NUM_CLS  = NUM_FL * NUM_SL;
  localparam int K_W      = FL_W + SL_LOG2;
  localparam int SLOT_W   = 10;
  localparam int LEN_W    = 11;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [K_W-1:0]     cls_idx_t;

  typedef struct packed {
    slot_t off;
    len_t  len;
    slot_t prev;
    slot_t next;
    slot_t fprev;
    slot_t fnext;
    logic  pv;
    logic  nv;
    logic  fpv;
    logic  fnv;
    logic  alloc;
  } desc_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_SIZE = 2'd1;
  localparam status_t ST_NO_FIT   = 2'd2;
  localparam status_t ST_IGNORED  = 2'd3;

  typedef enum logic [1:0] {
    RMW_PREV,
    RMW_FPREV,
    RMW_FNEXT
  } rmw_kind_t;

  typedef struct packed {
    logic [3:0]         fl;
    logic [SL_LOG2-1:0] sl;
    logic [3:0]         g;
  } cls_t;

  // first level linear below 2^LIN_LOG2, else from the top set bit
  function automatic cls_t class_of(len_t len);
    cls_t c;
    int   msb;
    msb = 0;
    for (int i = 0; i < LEN_W; i++) begin
      if (len[i]) msb = i;
    end
    if (len < len_t'(1 << LIN_LOG2)) begin
      c.fl = 4'd0;
      c.g  = 4'(LIN_LOG2 - SL_LOG2);
    end else begin
      c.fl = 4'(msb + 1 - LIN_LOG2);
      c.g  = 4'(msb - SL_LOG2);
    end
    c.sl = SL_LOG2'(len >> c.g);
    return c;
  endfunction

  function automatic logic [SL_LOG2-1:0] lowest_sl(logic [NUM_SL-1:0] v);
    logic [SL_LOG2-1:0] r;
    r = '0;
    for (int i = NUM_SL - 1; i >= 0; i--) begin
      if (v[i]) r = SL_LOG2'(i);
    end
    return r;
  endfunction

  function automatic logic [FL_W-1:0] lowest_fl(logic [NUM_FL-1:0] v);
    logic [FL_W-1:0] r;
    r = '0;
    for (int i = NUM_FL - 1; i >= 0; i--) begin
      if (v[i]) r = FL_W'(i);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/tlsf_range_allocator.sv */
// Two-level segregated-fit range allocator over 1024 units.
// Input channel s_*: one word per request. tuser[0] is op (0 allocate,
// 1 free), tuser[1] is handle_present. tdata carries size and handle.
// Output channel m_*: one result word per request, in request order:
// status, handle_res, offset and granted_size.
// Each request runs as a sequence of single-port descriptor memory
// reads and read-modify-writes under one small sequencer, so s_tready
// is high only while the sequencer is idle.
// A zero size or a free of null goes straight to the result. A failed
// search ends at the class lookup or once the found block is loaded, a
// bad handle once its descriptor is loaded, an allocate after unlink,
// split and relink, a free after its merges, longest when it merges with
// both neighbors; each neighbor update is a read-modify-write on the
// single port. The sequencer returns to idle before the next word is
// taken. After reset a clearing pass over all 1024 slots initializes the
// descriptor memory and spare slot stack; s_tready stays low meanwhile.
// The result waits in an output register: if m_tready is low the next
// request is still taken and processed, and the block waits at the end
// of that one until the output register is free.
module tlsf_range_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // size[10:0], handle[20:11], zero fill
  input  logic [1:0]  s_tuser,   // op[0], handle_present[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], handle_res[11:2], offset[21:12],
                                 // granted_size[32:22], zero fill
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LD_REQ, S_LD_CAP, S_RMW_RD, S_RMW_WR,
    S_UF0, S_UF1, S_UF2, S_FL0,
    S_A_FIND, S_A_CHECK, S_A_SPLIT, S_A_POP, S_A_FILE, S_A_WRC, S_A_DONE,
    S_F_CHK, S_F_PCHK, S_F_PMRG, S_F_PZ, S_F_N, S_F_NCHK, S_F_NMRG, S_F_NZ,
    S_F_FILE, S_F_WR, S_FIN
  } state_t;

  localparam tra_pkg::cls_t     RST_CLS = tra_pkg::class_of(tra_pkg::len_t'(tra_pkg::CAPACITY));
  localparam tra_pkg::cls_idx_t RST_K   = {RST_CLS.fl[tra_pkg::FL_W-1:0], RST_CLS.sl};

  // descriptor memory and spare slot stack
  tra_pkg::desc_t desc_mem [tra_pkg::CAPACITY];
  tra_pkg::slot_t stk_mem  [tra_pkg::CAPACITY];
  tra_pkg::desc_t desc_rdata;
  tra_pkg::slot_t stk_rdata;

  tra_pkg::slot_t desc_raddr, desc_waddr, stk_waddr, stk_wdata, stk_raddr;
  logic           desc_we, stk_we;
  tra_pkg::desc_t desc_wdata;

  state_t               state, ret, ret2;
  tra_pkg::slot_t       clr_cnt;
  tra_pkg::desc_t       cd, od;        // current block, other block
  tra_pkg::slot_t       cs, os;
  tra_pkg::slot_t       ld_addr;
  logic                 ld_to_od;
  tra_pkg::rmw_kind_t   rmw_kind;
  tra_pkg::slot_t       rmw_addr, rmw_val;
  logic                 rmw_vb;
  tra_pkg::len_t        size_q;
  logic [tra_pkg::LEN_W-1:0] spare_count;
  tra_pkg::slot_t       head_slot [tra_pkg::NUM_CLS];
  logic [tra_pkg::NUM_CLS-1:0] head_valid;
  logic [tra_pkg::NUM_CLS-1:0] sl_bits;   // bit k = {fl, sl}
  logic [tra_pkg::NUM_FL-1:0]  fl_map;
  tra_pkg::status_t     res_status;
  tra_pkg::slot_t       res_h, res_off;
  tra_pkg::len_t        res_len;

  // class lookups
  tra_pkg::cls_t        od_cls, cd_cls, rq_cls;
  tra_pkg::cls_idx_t    od_k, cd_k, fk, hk;
  tra_pkg::slot_t       hs_rd;
  logic                 hv_rd;
  logic [tra_pkg::NUM_FL-1:0] fl_from_sl;

  // search results
  logic [3:0]                   rfl;
  logic [tra_pkg::SL_LOG2-1:0]  rsl;
  logic [tra_pkg::FL_W-1:0]     ffl;
  logic [tra_pkg::SL_LOG2-1:0]  fsl;
  logic                         fok;
  logic [tra_pkg::NUM_SL-1:0]   slm;
  logic [tra_pkg::NUM_FL-1:0]   flm;
  tra_pkg::len_t                rmask;

  assign od_cls = tra_pkg::class_of(od.len);
  assign cd_cls = tra_pkg::class_of(cd.len);
  assign rq_cls = tra_pkg::class_of(size_q);
  assign od_k   = {od_cls.fl[tra_pkg::FL_W-1:0], od_cls.sl};
  assign cd_k   = {cd_cls.fl[tra_pkg::FL_W-1:0], cd_cls.sl};

  // good-fit search: round up to next class start, then bitmaps
  always_comb begin
    rmask = (tra_pkg::len_t'(1) << rq_cls.g) - tra_pkg::len_t'(1);
    rfl   = rq_cls.fl;
    rsl   = rq_cls.sl;
    if ((size_q & rmask) != '0) begin
      if (rq_cls.sl == tra_pkg::SL_LOG2'(tra_pkg::NUM_SL - 1)) begin
        rsl = '0;
        rfl = rq_cls.fl + 4'd1;
      end else begin
        rsl = rq_cls.sl + tra_pkg::SL_LOG2'(1);
      end
    end
    slm = sl_bits[rfl[tra_pkg::FL_W-1:0]*tra_pkg::NUM_SL +: tra_pkg::NUM_SL]
          & ({tra_pkg::NUM_SL{1'b1}} << rsl);
    flm = fl_map & ({tra_pkg::NUM_FL{1'b1}} << (rfl + 4'd1));
    ffl = rfl[tra_pkg::FL_W-1:0];
    fsl = '0;
    fok = 1'b0;
    if (rfl[3]) begin
      fok = 1'b0;
    end else if (slm != '0) begin
      fsl = tra_pkg::lowest_sl(slm);
      fok = 1'b1;
    end else if (flm != '0) begin
      ffl = tra_pkg::lowest_fl(flm);
      fsl = tra_pkg::lowest_sl(sl_bits[ffl*tra_pkg::NUM_SL +: tra_pkg::NUM_SL]);
      fok = sl_bits[ffl*tra_pkg::NUM_SL +: tra_pkg::NUM_SL] != '0;
    end
    fk = {ffl, fsl};
  end

  // single read port on the class heads
  always_comb begin
    case (state)
      S_A_FIND: hk = fk;
      S_UF2:    hk = od_k;
      default:  hk = cd_k;
    endcase
  end
  assign hs_rd = head_slot[hk];
  assign hv_rd = head_valid[hk];

  always_comb begin
    for (int i = 0; i < tra_pkg::NUM_FL; i++) begin
      fl_from_sl[i] = |sl_bits[i*tra_pkg::NUM_SL +: tra_pkg::NUM_SL];
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign stk_raddr = tra_pkg::SLOT_W'(spare_count - tra_pkg::LEN_W'(1));

  // memory port control
  always_comb begin
    desc_raddr = '0;
    desc_we    = 1'b0;
    desc_waddr = '0;
    desc_wdata = '0;
    stk_we     = 1'b0;
    stk_waddr  = spare_count[tra_pkg::SLOT_W-1:0];
    stk_wdata  = '0;
    case (state)
      S_CLEAR: begin
        desc_we    = 1'b1;
        desc_waddr = clr_cnt;
        if (clr_cnt == tra_pkg::SLOT_W'(tra_pkg::CAPACITY - 1)) begin
          desc_wdata.len = tra_pkg::len_t'(tra_pkg::CAPACITY);
        end
        stk_we    = 1'b1;
        stk_waddr = clr_cnt;
        stk_wdata = clr_cnt;
      end
      S_LD_REQ: desc_raddr = ld_addr;
      S_RMW_RD: desc_raddr = rmw_addr;
      S_RMW_WR: begin
        desc_we    = 1'b1;
        desc_waddr = rmw_addr;
        desc_wdata = desc_rdata;
        case (rmw_kind)
          tra_pkg::RMW_PREV: begin
            desc_wdata.prev = rmw_val;
            desc_wdata.pv   = rmw_vb;
          end
          tra_pkg::RMW_FPREV: begin
            desc_wdata.fprev = rmw_val;
            desc_wdata.fpv   = rmw_vb;
          end
          tra_pkg::RMW_FNEXT: begin
            desc_wdata.fnext = rmw_val;
            desc_wdata.fnv   = rmw_vb;
          end
          default: desc_wdata = desc_rdata;
        endcase
      end
      S_A_WRC, S_F_WR: begin
        desc_we    = 1'b1;
        desc_waddr = cs;
        desc_wdata = cd;
      end
      S_A_DONE: begin
        desc_we          = 1'b1;
        desc_waddr       = os;
        desc_wdata       = od;
        desc_wdata.alloc = 1'b1;
      end
      S_F_PZ: begin
        desc_we    = 1'b1;
        desc_waddr = cs;
        stk_we     = spare_count < tra_pkg::LEN_W'(tra_pkg::CAPACITY);
        stk_wdata  = cs;
      end
      S_F_NZ: begin
        desc_we    = 1'b1;
        desc_waddr = os;
        stk_we     = spare_count < tra_pkg::LEN_W'(tra_pkg::CAPACITY);
        stk_wdata  = os;
      end
      default: desc_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (desc_we) desc_mem[desc_waddr] <= desc_wdata;
    desc_rdata <= desc_mem[desc_raddr];
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rdata <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      clr_cnt           <= '0;
      spare_count       <= tra_pkg::LEN_W'(tra_pkg::CAPACITY - 1);
      head_valid        <= tra_pkg::NUM_CLS'(1) << RST_K;
      head_slot[RST_K]  <= tra_pkg::SLOT_W'(tra_pkg::CAPACITY - 1);
      sl_bits           <= tra_pkg::NUM_CLS'(1) << RST_K;
      fl_map            <= tra_pkg::NUM_FL'(1) << RST_CLS.fl;
      m_tvalid          <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + tra_pkg::SLOT_W'(1);
          if (clr_cnt == tra_pkg::SLOT_W'(tra_pkg::CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            size_q  <= s_tdata[10:0];
            res_h   <= '0;
            res_off <= '0;
            res_len <= '0;
            if (s_tuser[0]) begin
              if (!s_tuser[1]) begin
                res_status <= tra_pkg::ST_IGNORED;
                state      <= S_FIN;
              end else begin
                ld_addr  <= s_tdata[20:11];
                cs       <= s_tdata[20:11];
                ld_to_od <= 1'b0;
                ret      <= S_F_CHK;
                state    <= S_LD_REQ;
              end
            end else if (s_tdata[10:0] == '0) begin
              res_status <= tra_pkg::ST_BAD_SIZE;
              state      <= S_FIN;
            end else begin
              state <= S_A_FIND;
            end
          end
        end
        S_LD_REQ: state <= S_LD_CAP;
        S_LD_CAP: begin
          if (ld_to_od) od <= desc_rdata;
          else cd <= desc_rdata;
          state <= ret;
        end
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: state <= ret;
        // unlink od from its class list
        S_UF0: begin
          if (od.fnv) begin
            rmw_kind <= tra_pkg::RMW_FPREV;
            rmw_addr <= od.fnext;
            rmw_val  <= od.fprev;
            rmw_vb   <= od.fpv;
            ret      <= S_UF1;
            state    <= S_RMW_RD;
          end else begin
            state <= S_UF1;
          end
        end
        S_UF1: begin
          if (od.fpv) begin
            rmw_kind <= tra_pkg::RMW_FNEXT;
            rmw_addr <= od.fprev;
            rmw_val  <= od.fnext;
            rmw_vb   <= od.fnv;
            ret      <= S_UF2;
            state    <= S_RMW_RD;
          end else begin
            state <= S_UF2;
          end
        end
        S_UF2: begin
          if (hv_rd && hs_rd == os) begin
            head_slot[od_k]  <= od.fnext;
            head_valid[od_k] <= od.fnv;
            if (!od.fnv) begin
              sl_bits[od_k] <= 1'b0;
              if ((sl_bits[od_cls.fl[tra_pkg::FL_W-1:0]*tra_pkg::NUM_SL +: tra_pkg::NUM_SL]
                   & ~(tra_pkg::NUM_SL'(1) << od_cls.sl)) == '0) begin
                fl_map[od_cls.fl[tra_pkg::FL_W-1:0]] <= 1'b0;
              end
            end
          end
          od.fprev <= '0;
          od.fnext <= '0;
          od.fpv   <= 1'b0;
          od.fnv   <= 1'b0;
          state    <= ret2;
        end
        // push cd on the head of its class list
        S_FL0: begin
          head_slot[cd_k]  <= cs;
          head_valid[cd_k] <= 1'b1;
          sl_bits[cd_k]    <= 1'b1;
          fl_map[cd_cls.fl[tra_pkg::FL_W-1:0]] <= 1'b1;
          cd.fpv   <= 1'b0;
          cd.fnv   <= hv_rd;
          cd.fnext <= hs_rd;
          if (hv_rd) begin
            rmw_kind <= tra_pkg::RMW_FPREV;
            rmw_addr <= hs_rd;
            rmw_val  <= cs;
            rmw_vb   <= 1'b1;
            ret      <= ret2;
            state    <= S_RMW_RD;
          end else begin
            state <= ret2;
          end
        end
        S_A_FIND: begin
          if (!fok || !hv_rd) begin
            res_status <= tra_pkg::ST_NO_FIT;
            state      <= S_FIN;
          end else begin
            os       <= hs_rd;
            ld_addr  <= hs_rd;
            ld_to_od <= 1'b1;
            ret      <= S_A_CHECK;
            state    <= S_LD_REQ;
          end
        end
        S_A_CHECK: begin
          if (od.len < size_q || (od.len > size_q && spare_count == '0)) begin
            res_status <= tra_pkg::ST_NO_FIT;
            state      <= S_FIN;
          end else begin
            ret2  <= S_A_SPLIT;
            state <= S_UF0;
          end
        end
        S_A_SPLIT: begin
          if (od.len > size_q) begin
            spare_count <= spare_count - tra_pkg::LEN_W'(1);
            state       <= S_A_POP;
          end else begin
            state <= S_A_DONE;
          end
        end
        S_A_POP: begin
          cd.fprev <= '0;
          cd.fnext <= '0;
          cd.fpv   <= 1'b0;
          cd.fnv   <= 1'b0;
          cd.alloc <= 1'b0;
          cd.off   <= od.off + size_q[tra_pkg::SLOT_W-1:0];
          cd.len   <= od.len - size_q;
          cd.prev  <= os;
          cd.pv    <= 1'b1;
          cd.next  <= od.next;
          cd.nv    <= od.nv;
          cs       <= stk_rdata;
          od.next  <= stk_rdata;
          od.nv    <= 1'b1;
          od.len   <= size_q;
          if (od.nv) begin
            rmw_kind <= tra_pkg::RMW_PREV;
            rmw_addr <= od.next;
            rmw_val  <= stk_rdata;
            rmw_vb   <= 1'b1;
            ret      <= S_A_FILE;
            state    <= S_RMW_RD;
          end else begin
            state <= S_A_FILE;
          end
        end
        S_A_FILE: begin
          ret2  <= S_A_WRC;
          state <= S_FL0;
        end
        S_A_WRC: state <= S_A_DONE;
        S_A_DONE: begin
          res_status <= tra_pkg::ST_OK;
          res_h      <= os;
          res_off    <= od.off;
          res_len    <= size_q;
          state      <= S_FIN;
        end
        S_F_CHK: begin
          if (!cd.alloc) begin
            res_status <= tra_pkg::ST_IGNORED;
            state      <= S_FIN;
          end else begin
            cd.alloc <= 1'b0;
            if (cd.pv) begin
              os       <= cd.prev;
              ld_addr  <= cd.prev;
              ld_to_od <= 1'b1;
              ret      <= S_F_PCHK;
              state    <= S_LD_REQ;
            end else begin
              state <= S_F_N;
            end
          end
        end
        S_F_PCHK: begin
          if (!od.alloc) begin
            ret2  <= S_F_PMRG;
            state <= S_UF0;
          end else begin
            state <= S_F_N;
          end
        end
        S_F_PMRG: begin
          od.len  <= od.len + cd.len;
          od.next <= cd.next;
          od.nv   <= cd.nv;
          if (cd.nv) begin
            rmw_kind <= tra_pkg::RMW_PREV;
            rmw_addr <= cd.next;
            rmw_val  <= os;
            rmw_vb   <= 1'b1;
            ret      <= S_F_PZ;
            state    <= S_RMW_RD;
          end else begin
            state <= S_F_PZ;
          end
        end
        S_F_PZ: begin
          if (spare_count < tra_pkg::LEN_W'(tra_pkg::CAPACITY)) begin
            spare_count <= spare_count + tra_pkg::LEN_W'(1);
          end
          cd    <= od;
          cs    <= os;
          state <= S_F_N;
        end
        S_F_N: begin
          if (cd.nv) begin
            os       <= cd.next;
            ld_addr  <= cd.next;
            ld_to_od <= 1'b1;
            ret      <= S_F_NCHK;
            state    <= S_LD_REQ;
          end else begin
            state <= S_F_FILE;
          end
        end
        S_F_NCHK: begin
          if (!od.alloc) begin
            ret2  <= S_F_NMRG;
            state <= S_UF0;
          end else begin
            state <= S_F_FILE;
          end
        end
        S_F_NMRG: begin
          cd.len  <= cd.len + od.len;
          cd.next <= od.next;
          cd.nv   <= od.nv;
          if (od.nv) begin
            rmw_kind <= tra_pkg::RMW_PREV;
            rmw_addr <= od.next;
            rmw_val  <= cs;
            rmw_vb   <= 1'b1;
            ret      <= S_F_NZ;
            state    <= S_RMW_RD;
          end else begin
            state <= S_F_NZ;
          end
        end
        S_F_NZ: begin
          if (spare_count < tra_pkg::LEN_W'(tra_pkg::CAPACITY)) begin
            spare_count <= spare_count + tra_pkg::LEN_W'(1);
          end
          state <= S_F_FILE;
        end
        S_F_FILE: begin
          ret2  <= S_F_WR;
          state <= S_FL0;
        end
        S_F_WR: begin
          res_status <= tra_pkg::ST_OK;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res_len, res_off, res_h, res_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // at least one block always holds a descriptor
  a_spare_bound: assert property (@(posedge clk) disable iff (rst)
    spare_count <= tra_pkg::LEN_W'(tra_pkg::CAPACITY - 1))
    else $error("spare slot count out of range");

  // first-level map tracks non-empty second-level maps
  a_map_consistent: assert property (@(posedge clk) disable iff (rst)
    fl_map == fl_from_sl)
    else $error("first-level map out of step with second-level maps");

  // a finished request reaches the output register
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("result not presented");

endmodule

/* sim/tlsf_range_allocator_test.sv */
`timescale 1ns / 1ps

module tlsf_range_allocator_test;

  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       op;
    logic [10:0] size;
    logic [9:0] handle;
    logic       present;
  } req_t;

  // packed from the top bit down: granted_size, offset, handle_res, status
  typedef struct packed {
    logic [10:0]      granted;
    logic [9:0]       offset;
    logic [9:0]       handle_res;
    tra_pkg::status_t status;
  } grant_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // size[10:0], handle[20:11], zero fill
  logic [1:0]  s_tuser;   // op[0], handle_present[1]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // status[1:0], handle_res[11:2], offset[21:12],
                          // granted_size[32:22], zero fill

  tlsf_range_allocator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // ---------------------------------------------------------------------
  // Allocator mirror: descriptor table, spare stack, class heads, bitmaps
  // ---------------------------------------------------------------------
  typedef struct {
    int unsigned off, len, prev, next, fprev, fnext;
    bit pv, nv, fpv, fnv, alloc;
  } mblk_t;

  mblk_t       blk[tra_pkg::CAPACITY];
  int unsigned spare_stack[tra_pkg::CAPACITY];
  int unsigned spare_cnt;
  int unsigned head_slot[32*tra_pkg::NUM_SL];
  bit          head_ok[32*tra_pkg::NUM_SL];
  int unsigned fl_map;
  int unsigned sl_map[32];

  function automatic int unsigned low_bit(int unsigned v);
    int unsigned i;
    i = 0;
    while (i < 31 && !v[i]) i++;
    return i;
  endfunction

  function automatic void size_class(int unsigned sz, output int unsigned fl,
                                     output int unsigned sl, output int unsigned g);
    int unsigned msb;
    if (sz < (1 << tra_pkg::LIN_LOG2)) begin
      fl = 0;
      g  = tra_pkg::LIN_LOG2 - tra_pkg::SL_LOG2;
    end else begin
      msb = 31;
      while (msb > 0 && !sz[msb]) msb--;
      fl = (msb + 1 - tra_pkg::LIN_LOG2) & 31;
      g  = msb - tra_pkg::SL_LOG2;
    end
    sl = (sz >> g) & (tra_pkg::NUM_SL - 1);
  endfunction

  function automatic void link_free(int unsigned b);
    int unsigned fl, sl, g, k;
    size_class(blk[b].len, fl, sl, g);
    k = fl * tra_pkg::NUM_SL + sl;
    blk[b].fpv = 0;
    blk[b].fnv = head_ok[k];
    blk[b].fnext = head_slot[k];
    if (head_ok[k]) begin
      blk[head_slot[k]].fprev = b;
      blk[head_slot[k]].fpv = 1;
    end
    head_slot[k] = b;
    head_ok[k] = 1;
    fl_map |= 1 << fl;
    sl_map[fl] |= 1 << sl;
  endfunction

  function automatic void unlink_free(int unsigned b);
    int unsigned fl, sl, g, k;
    if (blk[b].fnv) begin
      blk[blk[b].fnext].fprev = blk[b].fprev;
      blk[blk[b].fnext].fpv = blk[b].fpv;
    end
    if (blk[b].fpv) begin
      blk[blk[b].fprev].fnext = blk[b].fnext;
      blk[blk[b].fprev].fnv = blk[b].fnv;
    end
    size_class(blk[b].len, fl, sl, g);
    k = fl * tra_pkg::NUM_SL + sl;
    if (head_ok[k] && head_slot[k] == b) begin
      head_slot[k] = blk[b].fnext;
      head_ok[k] = blk[b].fnv;
      if (!blk[b].fnv) begin
        sl_map[fl] &= ~(1 << sl);
        if (sl_map[fl] == 0) fl_map &= ~(1 << fl);
      end
    end
    blk[b].fpv = 0; blk[b].fnv = 0; blk[b].fprev = 0; blk[b].fnext = 0;
  endfunction

  function automatic int unsigned coalesce(int unsigned a, int unsigned c);
    unlink_free(a);
    unlink_free(c);
    blk[a].len += blk[c].len;
    blk[a].next = blk[c].next;
    blk[a].nv = blk[c].nv;
    if (blk[c].nv) begin
      blk[blk[c].next].prev = a;
      blk[blk[c].next].pv = 1;
    end
    blk[c] = '{default: 0};
    if (spare_cnt < tra_pkg::CAPACITY) begin
      spare_stack[spare_cnt] = c;
      spare_cnt++;
    end
    return a;
  endfunction

  function automatic void mirror_reset();
    for (int i = 0; i < tra_pkg::CAPACITY; i++) begin
      blk[i] = '{default: 0};
      spare_stack[i] = i;
    end
    for (int i = 0; i < 32*tra_pkg::NUM_SL; i++) begin
      head_slot[i] = 0; head_ok[i] = 0;
    end
    for (int i = 0; i < 32; i++) sl_map[i] = 0;
    fl_map = 0;
    spare_cnt = tra_pkg::CAPACITY - 1;
    blk[tra_pkg::CAPACITY-1].len = tra_pkg::CAPACITY;
    link_free(tra_pkg::CAPACITY - 1);
  endfunction

  // live handles, so that most frees name a real block
  int unsigned live[$];

  function automatic grant_t serve(req_t r);
    grant_t      o;
    int unsigned fl, sl, g, slm, flm, b, k, sz, rs;
    bit          found;
    o = '0;
    sz = r.size;
    if (r.op) begin
      if (!r.present || !blk[r.handle].alloc) begin
        o.status = tra_pkg::ST_IGNORED;
      end else begin
        b = r.handle;
        blk[b].alloc = 0;
        if (blk[b].pv && !blk[blk[b].prev].alloc) b = coalesce(blk[b].prev, b);
        if (blk[b].nv && !blk[blk[b].next].alloc) b = coalesce(b, blk[b].next);
        link_free(b);
        o.status = tra_pkg::ST_OK;
      end
      return o;
    end
    if (sz == 0) begin
      o.status = tra_pkg::ST_BAD_SIZE;
      return o;
    end
    found = 1;
    size_class(sz, fl, sl, g);
    // round up to the next class start so any block found fits
    if (sz & ((1 << g) - 1)) begin
      sl++;
      if (sl >= tra_pkg::NUM_SL) begin sl = 0; fl++; end
    end
    if (fl >= 32) found = 0;
    else begin
      slm = sl_map[fl] & (32'hFFFF_FFFF << sl);
      if (slm != 0) sl = low_bit(slm);
      else begin
        flm = (fl + 1 < 32) ? (fl_map & (32'hFFFF_FFFF << (fl + 1))) : 0;
        if (flm == 0) found = 0;
        else begin
          fl = low_bit(flm);
          if (sl_map[fl] == 0) found = 0;
          else sl = low_bit(sl_map[fl]);
        end
      end
    end
    if (found) begin
      k = fl * tra_pkg::NUM_SL + sl;
      if (!head_ok[k]) found = 0;
      else begin
        b = head_slot[k];
        if (blk[b].len < sz || (blk[b].len > sz && spare_cnt == 0)) found = 0;
      end
    end
    if (!found) begin
      o.status = tra_pkg::ST_NO_FIT;
      return o;
    end
    b = head_slot[fl * tra_pkg::NUM_SL + sl];
    unlink_free(b);
    if (blk[b].len > sz) begin
      spare_cnt--;
      rs = spare_stack[spare_cnt];
      blk[rs] = '{default: 0};
      blk[rs].off = blk[b].off + sz;
      blk[rs].len = blk[b].len - sz;
      blk[rs].prev = b;
      blk[rs].pv = 1;
      blk[rs].next = blk[b].next;
      blk[rs].nv = blk[b].nv;
      if (blk[b].nv) begin
        blk[blk[b].next].prev = rs;
        blk[blk[b].next].pv = 1;
      end
      blk[b].next = rs;
      blk[b].nv = 1;
      blk[b].len = sz;
      link_free(rs);
    end
    blk[b].alloc = 1;
    o.status = tra_pkg::ST_OK;
    o.handle_res = 10'(b);
    o.offset = 10'(blk[b].off);
    o.granted = 11'(sz);
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Request queue: directed words, then random traffic
  // ---------------------------------------------------------------------
  req_t pending_reqs[$];
  int   n_fail, n_words, n_allocs, n_frees;
  int   rand_left;
  bit   stim_done;

  function automatic req_t mk(bit op, int unsigned sz, int unsigned h, bit p);
    req_t r;
    r.op = op; r.size = 11'(sz); r.handle = 10'(h); r.present = p;
    return r;
  endfunction

  function automatic void add_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  initial begin
    add_req(mk(0, 0, 0, 0));          // zero size
    add_req(mk(0, 2047, 1023, 1));    // above capacity
    add_req(mk(1, 0, 5, 0));          // free of null
    add_req(mk(1, 0, 1023, 1));       // free of the free whole range
    add_req(mk(1, 0, 0, 1));          // free of a spare slot
    add_req(mk(0, 1024, 0, 0));       // whole range
    add_req(mk(0, 1, 0, 0));          // nothing left
    add_req(mk(1, 0, 1023, 1));       // give it back
    add_req(mk(1, 0, 1023, 1));       // double free
    add_req(mk(0, 1, 0, 0));
    add_req(mk(0, 63, 0, 0));
    add_req(mk(0, 64, 0, 0));
    add_req(mk(0, 65, 0, 0));
    add_req(mk(0, 255, 0, 0));
    add_req(mk(0, 512, 0, 0));
    add_req(mk(0, 1024, 0, 0));       // no fit after splits
    rand_left = 550;
  end

  // ---------------------------------------------------------------------
  // Driver: new requests are built at accept time so frees pick live slots
  // ---------------------------------------------------------------------
  grant_t expected_grants[$];
  int     idle_phase;   // cycle count; a calm stretch with no idling

  function automatic req_t random_req();
    req_t r;
    int   pick;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.op = 0;
      case ($urandom_range(0, 3))
        0: r.size = 11'($urandom_range(1, 63));
        1: r.size = 11'($urandom_range(64, 255));
        2: r.size = 11'($urandom_range(1, 1024));
        default: r.size = 11'($urandom_range(0, 2047));
      endcase
      r.handle = 10'($urandom);
      r.present = 1'($urandom);
    end else if (pick < 90 && live.size() > 0) begin
      r.op = 1;
      r.handle = 10'(live[$urandom_range(0, live.size() - 1)]);
      r.present = 1;
      r.size = 11'($urandom);
    end else begin
      r.op = 1;
      r.handle = 10'($urandom);
      r.present = 1'($urandom);
      r.size = 11'($urandom);
    end
    return r;
  endfunction

  req_t cur;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tdata <= '0;
      s_tuser <= '0;
      idle_phase <= 0;
    end else begin
      idle_phase <= idle_phase + 1;
      if (!s_tvalid || s_tready) begin
        if (s_tvalid) begin
          expected_grants = {expected_grants, serve(cur)};
          n_words++;
          if (cur.op) begin
            n_frees++;
            for (int i = 0; i < live.size(); i++) begin
              if (live[i] == cur.handle && !blk[cur.handle].alloc) begin
                live.delete(i);
                break;
              end
            end
          end else if (expected_grants[$].status == tra_pkg::ST_OK) begin
            n_allocs++;
            live = {live, int'(expected_grants[$].handle_res)};
          end
        end
        if (pending_reqs.size() == 0 && rand_left > 0) begin
          add_req(random_req());
          rand_left--;
        end
        if (pending_reqs.size() > 0 &&
            ((idle_phase > 2000 && idle_phase < 3500) || $urandom_range(0, 99) >= 23)) begin
          cur = pending_reqs.pop_front();
          s_tvalid <= 1;
          s_tdata <= {3'b0, cur.handle, cur.size};
          s_tuser <= {cur.present, cur.op};
        end else begin
          s_tvalid <= 0;
          if (pending_reqs.size() == 0 && rand_left == 0) stim_done <= 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: ready with random stalls and one long hold-off
  // ---------------------------------------------------------------------
  int hold_cnt;
  grant_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      hold_cnt <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[32:0];
        if (expected_grants.size() == 0) begin
          $display("%0t unexpected result word %h", $realtime, got);
          n_fail++;
        end else begin
          want = expected_grants.pop_front();
          if (got.status !== want.status)
            $display("%0t status exp %0d act %0d", $realtime, want.status, got.status);
          if (got.handle_res !== want.handle_res)
            $display("%0t handle exp %0d act %0d", $realtime, want.handle_res, got.handle_res);
          if (got.offset !== want.offset)
            $display("%0t offset exp %0d act %0d", $realtime, want.offset, got.offset);
          if (got.granted !== want.granted)
            $display("%0t granted exp %0d act %0d", $realtime, want.granted, got.granted);
          if (got !== want) n_fail++;
        end
      end
      // long hold-off once traffic is flowing, so the block backs up
      if (n_words == 40 && hold_cnt == 0) hold_cnt <= HOLD_CYCLES;
      if (hold_cnt > 1) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 0;
      end else begin
        if (hold_cnt == 1) hold_cnt <= -1;
        m_tready <= (idle_phase > 2000 && idle_phase < 3500) || $urandom_range(0, 99) >= 23;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence and end of run
  // ---------------------------------------------------------------------
  initial begin
    n_fail = 0; n_words = 0; n_allocs = 0; n_frees = 0;
    stim_done = 0;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
    mirror_reset();
    rst = 1;
    repeat (3) @(posedge clk);
    rst <= 0;
    wait (stim_done);
    wait (expected_grants.size() == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d request words: %0d grants, %0d frees, %0d live at end",
             n_words, n_allocs, n_frees, live.size());
    if (n_fail == 0 && expected_grants.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
